FILE: rtl/rqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared types, codes and default sizes for the request queue steering block.
// ----------------------------------------------------------------------------
package rqs_pkg;

   localparam int TARGET_SLOTS_DEFAULT = 64;
   localparam int MAX_QUEUES_DEFAULT   = 64;
   localparam int MAX_PENDING_DEFAULT  = 1024;

   localparam int TARGET_W     = 6;
   localparam int QUEUE_W      = 6;
   localparam int TICK_W       = 32;
   localparam int QCOUNT_W     = 7;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUIET_TICKS = 1'b1;

   localparam logic OP_SUBMIT   = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   localparam logic [QCOUNT_W-1:0] QUEUE_COUNT_RESET = 7'd1;
   localparam logic [TICK_W-1:0]   QUIET_TICKS_RESET = 32'd100;

   typedef struct packed {
      logic                op;
      logic [TARGET_W-1:0] target;
      logic [QUEUE_W-1:0]  queue;
      logic [TICK_W-1:0]   now;
      logic                ring_accepts;
   } req_payload_type;

   typedef struct packed {
      logic [QUEUE_W-1:0] chosen_queue;
      logic               accepted;
      logic               moved;
      logic               queue_freed;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_SWEEP_INIT,
      ST_SWEEP_MAP,
      ST_IDLE,
      ST_QREAD,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_queue;
      logic exec_fire;
      logic sweep_en;
      logic sweep_clear;
      logic sweep_restart;
   } cmd_type;

   typedef struct packed {
      logic req_submit;
      logic sweep_last;
      logic rsp_blocked;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/rqs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_ctrl
// Sequencer: init/map sweeps, item accept, queue count read and execute.
// ----------------------------------------------------------------------------
module rqs_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  qc_write,
   input  rqs_pkg::status_type  status,
   output rqs_pkg::cmd_type     cmd,
   output logic                 req_stall
);

   rqs_pkg::state_type state_ff;
   rqs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rqs_pkg::ST_SWEEP_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rqs_pkg::ST_SWEEP_INIT, rqs_pkg::ST_SWEEP_MAP: begin
            if (!qc_write && status.sweep_last) begin
               state_in = rqs_pkg::ST_IDLE;
            end
         end
         rqs_pkg::ST_IDLE: begin
            if (qc_write) begin
               state_in = rqs_pkg::ST_SWEEP_MAP;
            end else if (req_valid) begin
               state_in = status.req_submit ? rqs_pkg::ST_QREAD : rqs_pkg::ST_EXEC;
            end
         end
         rqs_pkg::ST_QREAD: begin
            state_in = rqs_pkg::ST_EXEC;
         end
         rqs_pkg::ST_EXEC: begin
            if (!status.rsp_blocked) begin
               state_in = rqs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rqs_pkg::ST_SWEEP_INIT;
         end
      endcase
   end

   always_comb begin
      cmd               = '0;
      cmd.sweep_restart = qc_write;
      req_stall         = 1'b1;
      case (state_ff)
         rqs_pkg::ST_SWEEP_INIT: begin
            cmd.sweep_en    = 1'b1;
            cmd.sweep_clear = 1'b1;
         end
         rqs_pkg::ST_SWEEP_MAP: begin
            cmd.sweep_en = 1'b1;
         end
         rqs_pkg::ST_IDLE: begin
            // hold off the transfer while a queue count write lands
            req_stall  = qc_write;
            cmd.accept = req_valid && !qc_write;
         end
         rqs_pkg::ST_QREAD: begin
            cmd.load_queue = 1'b1;
         end
         rqs_pkg::ST_EXEC: begin
            cmd.exec_fire = !status.rsp_blocked;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/rqs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_datapath
// Target and queue tables, free mask, configuration and result register.
// ----------------------------------------------------------------------------
module rqs_datapath #(
   parameter int TARGET_SLOTS = rqs_pkg::TARGET_SLOTS_DEFAULT,
   parameter int MAX_QUEUES   = rqs_pkg::MAX_QUEUES_DEFAULT,
   parameter int MAX_PENDING  = rqs_pkg::MAX_PENDING_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  rqs_pkg::req_payload_type             req_payload,
   input  wire                                  csr_write_en,
   input  wire [rqs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [rqs_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  rqs_pkg::cmd_type                     cmd,
   output rqs_pkg::status_type                  status,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output rqs_pkg::rsp_payload_type             rsp_payload
);

   localparam int TW        = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
   localparam int QW        = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
   localparam int PW        = $clog2(MAX_PENDING + 1);
   localparam int SWEEP_LEN = (TARGET_SLOTS > MAX_QUEUES) ? TARGET_SLOTS : MAX_QUEUES;
   localparam int SW        = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;
   localparam int QCW       = rqs_pkg::QCOUNT_W;
   localparam logic [PW-1:0]  PEND_MAX = PW'(MAX_PENDING);
   localparam logic [QCW-1:0] QC_MAX   = QCW'(MAX_QUEUES);

   // tables
   logic [QW-1:0]             target_queue_ff [TARGET_SLOTS];
   logic [PW-1:0]             target_pending_ff [TARGET_SLOTS];
   logic [rqs_pkg::TICK_W-1:0] target_time_ff [TARGET_SLOTS];
   logic [PW-1:0]             queue_pending_ff [MAX_QUEUES];

   // configuration and queue state
   logic [QCW-1:0]             queue_count_ff;
   logic [rqs_pkg::TICK_W-1:0] quiet_ticks_ff;
   logic [MAX_QUEUES-1:0]      free_ff;
   logic [MAX_QUEUES-1:0]      free_in;
   logic [QW-1:0]              lowest_ff;
   logic [QW-1:0]              lowest_in;
   logic                       any_free_ff;
   logic [SW-1:0]              sweep_idx_ff;
   logic [QW-1:0]              sweep_mod_ff;

   // item registers
   rqs_pkg::req_payload_type   item_ff;
   logic [QW-1:0]              tq_rd_ff;
   logic [PW-1:0]              tp_rd_ff;
   logic [rqs_pkg::TICK_W-1:0] tl_rd_ff;
   logic [PW-1:0]              qpa_rd_ff;
   logic [PW-1:0]              qpb_rd_ff;

   rqs_pkg::rsp_payload_type   rsp_payload_ff;
   rqs_pkg::rsp_payload_type   rsp_payload_in;
   logic                       rsp_valid_ff;

   // index narrowing
   logic [TW+rqs_pkg::TARGET_W-1:0] req_tgt_wide;
   logic [QW+rqs_pkg::QUEUE_W-1:0]  req_q_wide;
   logic [TW+rqs_pkg::TARGET_W-1:0] item_tgt_wide;
   logic [QW+rqs_pkg::QUEUE_W-1:0]  item_q_wide;
   logic [TW+SW-1:0]                sweep_tgt_wide;
   logic [QW+SW-1:0]                sweep_q_wide;
   logic [TW-1:0]                   req_tidx;
   logic [QW-1:0]                   req_qidx;
   logic [TW-1:0]                   item_tidx;
   logic [QW-1:0]                   item_qidx;
   logic [TW-1:0]                   sweep_tidx;
   logic [QW-1:0]                   sweep_qidx;

   assign req_tgt_wide   = {{TW{1'b0}}, req_payload.target};
   assign req_q_wide     = {{QW{1'b0}}, req_payload.queue};
   assign item_tgt_wide  = {{TW{1'b0}}, item_ff.target};
   assign item_q_wide    = {{QW{1'b0}}, item_ff.queue};
   assign sweep_tgt_wide = {{TW{1'b0}}, sweep_idx_ff};
   assign sweep_q_wide   = {{QW{1'b0}}, sweep_idx_ff};
   assign req_tidx       = req_tgt_wide[TW-1:0];
   assign req_qidx       = req_q_wide[QW-1:0];
   assign item_tidx      = item_tgt_wide[TW-1:0];
   assign item_qidx      = item_q_wide[QW-1:0];
   assign sweep_tidx     = sweep_tgt_wide[TW-1:0];
   assign sweep_qidx     = sweep_q_wide[QW-1:0];

   logic sweep_tgt_ok;
   logic sweep_q_ok;
   logic item_tgt_ok;
   logic item_q_ok;

   assign sweep_tgt_ok = 32'(sweep_idx_ff) < TARGET_SLOTS;
   assign sweep_q_ok   = 32'(sweep_idx_ff) < MAX_QUEUES;
   assign item_tgt_ok  = 32'(item_ff.target) < TARGET_SLOTS;
   assign item_q_ok    = 32'(item_ff.queue) < MAX_QUEUES;

   // configuration decode
   logic           qc_write;
   logic           qt_write;
   logic [QCW-1:0] qc_raw;
   logic [QCW-1:0] qc_clamped;
   logic [MAX_QUEUES-1:0] qc_mask;

   always_comb begin
      qc_write = 1'b0;
      qt_write = 1'b0;
      case (csr_index)
         rqs_pkg::CSR_QUEUE_COUNT: qc_write = csr_write_en;
         rqs_pkg::CSR_QUIET_TICKS: qt_write = csr_write_en;
         default: begin
            qc_write = 1'b0;
            qt_write = 1'b0;
         end
      endcase
   end

   assign qc_raw = csr_write_data[QCW-1:0];

   always_comb begin
      qc_clamped = qc_raw;
      if (qc_raw == '0) begin
         qc_clamped = QCW'(1);
      end else if (qc_raw > QC_MAX) begin
         qc_clamped = QC_MAX;
      end
      for (int i = 0; i < MAX_QUEUES; i++) begin
         qc_mask[i] = QCW'(i) < qc_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_count_ff <= rqs_pkg::QUEUE_COUNT_RESET;
         quiet_ticks_ff <= rqs_pkg::QUIET_TICKS_RESET;
      end else begin
         if (qc_write) begin
            queue_count_ff <= qc_clamped;
         end
         if (qt_write) begin
            quiet_ticks_ff <= csr_write_data[rqs_pkg::TICK_W-1:0];
         end
      end
   end

   // sweep counters: table index and running index modulo queue count
   logic [QCW-1:0] sweep_mod_next;

   assign sweep_mod_next = QCW'(sweep_mod_ff) + QCW'(1);

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_restart) begin
         sweep_idx_ff <= '0;
         sweep_mod_ff <= '0;
      end else if (cmd.sweep_en) begin
         sweep_idx_ff <= sweep_idx_ff + SW'(1);
         sweep_mod_ff <= (sweep_mod_next == queue_count_ff) ? '0 : sweep_mod_next[QW-1:0];
      end
   end

   assign status.sweep_last  = sweep_idx_ff == SW'(SWEEP_LEN - 1);
   assign status.req_submit  = req_payload.op == rqs_pkg::OP_SUBMIT;
   assign status.rsp_blocked = rsp_valid_ff && rsp_stall;

   // lowest free queue, registered
   always_comb begin
      lowest_in = '0;
      for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            lowest_in = QW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      lowest_ff   <= lowest_in;
      any_free_ff <= |free_ff;
   end

   // table reads
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff   <= req_payload;
         tq_rd_ff  <= target_queue_ff[req_tidx];
         tp_rd_ff  <= target_pending_ff[req_tidx];
         tl_rd_ff  <= target_time_ff[req_tidx];
         qpa_rd_ff <= queue_pending_ff[req_qidx];
      end else if (cmd.load_queue) begin
         qpa_rd_ff <= queue_pending_ff[tq_rd_ff];
         qpb_rd_ff <= queue_pending_ff[lowest_ff];
      end
   end

   // item execution
   logic                       is_submit;
   logic [rqs_pkg::TICK_W-1:0] elapsed;
   logic                       do_move;
   logic [QW-1:0]              cur_queue;
   logic [PW-1:0]              qp_sel;
   logic [PW-1:0]              qp_inc;
   logic [PW-1:0]              tp_inc;
   logic                       do_qdec;
   logic                       do_tdec;
   logic                       freed;

   assign is_submit = item_ff.op == rqs_pkg::OP_SUBMIT;
   assign elapsed   = item_ff.now - tl_rd_ff;
   assign do_move   = item_tgt_ok && (tp_rd_ff == '0) && (elapsed >= quiet_ticks_ff) &&
                      (qpa_rd_ff != '0) && any_free_ff;
   assign cur_queue = do_move ? lowest_ff : tq_rd_ff;
   assign qp_sel    = do_move ? qpb_rd_ff : qpa_rd_ff;
   assign qp_inc    = (qp_sel >= PEND_MAX) ? PEND_MAX : qp_sel + PW'(1);
   assign tp_inc    = (tp_rd_ff >= PEND_MAX) ? PEND_MAX : tp_rd_ff + PW'(1);
   assign do_qdec   = item_q_ok && (qpa_rd_ff != '0);
   assign do_tdec   = item_tgt_ok && (tp_rd_ff != '0);
   assign freed     = do_qdec && (qpa_rd_ff == PW'(1)) &&
                      ({1'b0, item_ff.queue} < queue_count_ff);

   // table write ports
   logic                       tq_we;
   logic [TW-1:0]              tq_wa;
   logic [QW-1:0]              tq_wd;
   logic                       tp_we;
   logic [TW-1:0]              tp_wa;
   logic [PW-1:0]              tp_wd;
   logic                       tl_we;
   logic [TW-1:0]              tl_wa;
   logic [rqs_pkg::TICK_W-1:0] tl_wd;
   logic                       qp_we;
   logic [QW-1:0]              qp_wa;
   logic [PW-1:0]              qp_wd;

   always_comb begin
      tq_we = 1'b0;
      tq_wa = item_tidx;
      tq_wd = lowest_ff;
      tp_we = 1'b0;
      tp_wa = item_tidx;
      tp_wd = tp_inc;
      tl_we = 1'b0;
      tl_wa = item_tidx;
      tl_wd = item_ff.now;
      qp_we = 1'b0;
      qp_wa = cur_queue;
      qp_wd = qp_inc;
      if (cmd.sweep_en) begin
         tq_we = sweep_tgt_ok;
         tq_wa = sweep_tidx;
         tq_wd = sweep_mod_ff;
         tp_we = sweep_tgt_ok && cmd.sweep_clear;
         tp_wa = sweep_tidx;
         tp_wd = '0;
         tl_we = sweep_tgt_ok && cmd.sweep_clear;
         tl_wa = sweep_tidx;
         tl_wd = '0;
         qp_we = sweep_q_ok && cmd.sweep_clear;
         qp_wa = sweep_qidx;
         qp_wd = '0;
      end else if (cmd.exec_fire) begin
         if (is_submit) begin
            tq_we = do_move;
            tp_we = item_tgt_ok;
            tl_we = item_tgt_ok;
            qp_we = item_tgt_ok && item_ff.ring_accepts;
         end else begin
            tp_we = do_tdec;
            tp_wd = tp_rd_ff - PW'(1);
            qp_we = do_qdec;
            qp_wa = item_qidx;
            qp_wd = qpa_rd_ff - PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tq_we) begin
         target_queue_ff[tq_wa] <= tq_wd;
      end
      if (tp_we) begin
         target_pending_ff[tp_wa] <= tp_wd;
      end
      if (tl_we) begin
         target_time_ff[tl_wa] <= tl_wd;
      end
      if (qp_we) begin
         queue_pending_ff[qp_wa] <= qp_wd;
      end
   end

   // free mask
   always_comb begin
      free_in = free_ff;
      if (qc_write) begin
         free_in = qc_mask;
      end else if (cmd.exec_fire) begin
         if (is_submit && do_move) begin
            free_in[lowest_ff] = 1'b0;
         end else if (!is_submit && freed) begin
            free_in[item_qidx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= MAX_QUEUES'(1);
      end else begin
         free_ff <= free_in;
      end
   end

   // result register
   always_comb begin
      rsp_payload_in = '0;
      if (is_submit) begin
         if (item_tgt_ok) begin
            rsp_payload_in.chosen_queue = rqs_pkg::QUEUE_W'(cur_queue);
            rsp_payload_in.accepted     = item_ff.ring_accepts;
            rsp_payload_in.moved        = do_move;
         end
      end else begin
         rsp_payload_in.chosen_queue = item_ff.queue;
         rsp_payload_in.queue_freed  = freed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

FILE: rtl/request_queue_steering.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// request_queue_steering
// Picks the request queue for each target's submits and tracks completions.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one submit or completion per transfer (req_valid high, req_stall
//            low). rsp_* : one result per item, in order.
//   csr_*  : write-only registers, queue count (index 0) and quiet ticks
//            (index 1); write them only while no item is in flight.
// Sequence:
//   A completion passes through the target table read, then execute; a
//   submit adds a queue read state between them, because the queue counts of the
//   target's current queue and of the lowest free queue are read from the
//   queue table after the target table read. The controller holds one item
//   at a time, so no new transfer is taken until the last item has left
//   execute.
// Reset and reconfiguration:
//   After reset a sweep over max(TARGET_SLOTS, MAX_QUEUES) entries clears the
//   pending counts and time stamps and loads the target map; req_stall is
//   held high meanwhile. A queue count write stalls req_* in its cycle and
//   starts a map sweep of the same length.
// Receiver stall:
//   The result register holds its transfer while rsp_stall is high; the next
//   item is still accepted and waits in execute until the register frees.
// ----------------------------------------------------------------------------
module request_queue_steering #(
   parameter int TARGET_SLOTS = rqs_pkg::TARGET_SLOTS_DEFAULT,
   parameter int MAX_QUEUES   = rqs_pkg::MAX_QUEUES_DEFAULT,
   parameter int MAX_PENDING  = rqs_pkg::MAX_PENDING_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  rqs_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output rqs_pkg::rsp_payload_type         rsp_payload,
   input  wire                              csr_write_en,
   input  wire [rqs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [rqs_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   rqs_pkg::cmd_type    cmd;
   rqs_pkg::status_type status;
   logic                qc_write;

   // a queue count write restarts the map sweep
   assign qc_write = csr_write_en && (csr_index == rqs_pkg::CSR_QUEUE_COUNT);

   rqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .qc_write  (qc_write),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   rqs_datapath #(
      .TARGET_SLOTS (TARGET_SLOTS),
      .MAX_QUEUES   (MAX_QUEUES),
      .MAX_PENDING  (MAX_PENDING)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

endmodule
`default_nettype wire
